// ===== hw/rtl/e2c_pkg.sv =====
// Shared types and constants for the epoch seconds to calendar converter.
package e2c_pkg;

    localparam int EPOCH_W = 32;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    // Whole days since the epoch: at most 49710, so 16 bits suffice.
    localparam int DAYS_W  = 16;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;

    // Time of day split off by the front end, plus the whole days that remain.
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [DAYS_W-1:0] days;
    } split_t;

endpackage

// ===== hw/rtl/e2c_ifs.sv =====
// Handshake channels for epoch input items and calendar result items.
interface e2c_epoch_if;
    logic                         valid;
    logic                         ready;
    logic [e2c_pkg::EPOCH_W-1:0]  epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_cal_if;
    logic                         valid;
    logic                         ready;
    logic [e2c_pkg::SEC_W-1:0]    second_of_minute;
    logic [e2c_pkg::MIN_W-1:0]    minute_of_hour;
    logic [e2c_pkg::HOUR_W-1:0]   hour_of_day;
    logic [e2c_pkg::DAY_W-1:0]    day_of_month;
    logic [e2c_pkg::MONTH_W-1:0]  month_of_year;
    logic [e2c_pkg::YEAR_W-1:0]   full_year;

    modport source (output valid, output second_of_minute, output minute_of_hour,
                    output hour_of_day, output day_of_month, output month_of_year,
                    output full_year, input ready);
    modport sink   (input valid, input second_of_minute, input minute_of_hour,
                    input hour_of_day, input day_of_month, input month_of_year,
                    input full_year, output ready);
endinterface

// ===== hw/rtl/e2c_front.sv =====
// Front end: accepts an epoch item and splits off seconds, minutes and hours.
module e2c_front
    import e2c_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    e2c_epoch_if.sink       in_ch,
    output logic            split_valid,
    input  logic            split_ready,
    output split_t          split_data
);

    // Reciprocals: floor(x/60) = (x * MULT_60) >> 37, floor(x/24) = (x * MULT_24) >> 36,
    // both exact for any 32-bit x.
    localparam logic [31:0] MULT_60 = 32'h8888_8889;
    localparam logic [31:0] MULT_24 = 32'hAAAA_AAAB;
    localparam logic [1:0]  STEP_SEC  = 2'd0;
    localparam logic [1:0]  STEP_MIN  = 2'd1;
    localparam logic [1:0]  STEP_HOUR = 2'd2;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_MUL   = 4'b0010,
        F_SPLIT = 4'b0100,
        F_PUSH  = 4'b1000
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [31:0]       x_reg, x_next;
    logic [63:0]       prod_reg, prod_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [HOUR_W-1:0] hour_reg, hour_next;

    logic [31:0] quot;
    logic [31:0] rem60;
    logic [31:0] rem24;

    assign in_ch.ready = (state_reg == F_IDLE);
    assign split_valid = (state_reg == F_PUSH);

    always_comb
    begin
        split_data      = '0;
        split_data.sec  = sec_reg;
        split_data.min  = min_reg;
        split_data.hour = hour_reg;
        split_data.days = x_reg[DAYS_W-1:0];
    end

    // Quotient and the two candidate remainders (constant multiplies are shift-adds).
    always_comb
    begin
        if (step_reg == STEP_HOUR)
        begin
            quot = {4'd0, prod_reg[63:36]};
        end
        else
        begin
            quot = {5'd0, prod_reg[63:37]};
        end
        rem60 = x_reg - ((quot << 6) - (quot << 2));
        rem24 = x_reg - ((quot << 4) + (quot << 3));
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                begin
                    x_next     = in_ch.epoch_seconds;
                    step_next  = STEP_SEC;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (step_reg == STEP_HOUR)
                begin
                    prod_next = x_reg * MULT_24;
                end
                else
                begin
                    prod_next = x_reg * MULT_60;
                end
                state_next = F_SPLIT;
            end
            F_SPLIT:
            begin
                x_next = quot;
                case (step_reg)
                    STEP_SEC:  sec_next  = rem60[SEC_W-1:0];
                    STEP_MIN:  min_next  = rem60[MIN_W-1:0];
                    default:   hour_next = rem24[HOUR_W-1:0];
                endcase
                if (step_reg == STEP_HOUR)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = F_MUL;
                end
            end
            F_PUSH:
            begin
                if (split_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= STEP_SEC;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
    end

endmodule

// ===== hw/rtl/e2c_queue.sv =====
// Short queue of split items between the front end and the calendar walker.
module e2c_queue
    import e2c_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  split_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output split_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    split_t            entry_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/e2c_back.sv =====
// Back end: walks years and months from the day count and holds the result.
module e2c_back
    import e2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      split_valid,
    output logic      split_ready,
    input  split_t    split_data,
    e2c_cal_if.source out_ch
);

    localparam logic [6:0] Y100_START = 7'd70;
    localparam logic [8:0] Y400_START = 9'd370;
    localparam logic [6:0] Y100_LAST  = 7'd99;
    localparam logic [8:0] Y400_LAST  = 9'd399;
    localparam logic [MONTH_W-1:0] DECEMBER_IDX = 4'd11;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_YEAR  = 4'b0010,
        B_MONTH = 4'b0100,
        B_HOLD  = 4'b1000
    } back_state_t;

    back_state_t        state_reg, state_next;
    split_t             item_reg, item_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [6:0]         y100_reg, y100_next;   // year mod 100
    logic [8:0]         y400_reg, y400_next;   // year mod 400
    logic [MONTH_W-1:0] month_reg, month_next;
    logic               out_valid_reg, out_valid_next;
    logic               load_out;

    logic [SEC_W-1:0]   o_sec_reg;
    logic [MIN_W-1:0]   o_min_reg;
    logic [HOUR_W-1:0]  o_hour_reg;
    logic [DAY_W-1:0]   o_day_reg;
    logic [MONTH_W-1:0] o_month_reg;
    logic [YEAR_W-1:0]  o_year_reg;

    logic               leap;
    logic [8:0]         year_len;
    logic [4:0]         month_len;

    assign leap     = (year_reg[1:0] == 2'd0) && ((y100_reg != '0) || (y400_reg == '0));
    assign year_len = leap ? 9'd366 : 9'd365;

    // Month lengths; February depends on the leap flag.
    always_comb
    begin
        case (month_reg)
            4'd1:                      month_len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    end

    assign split_ready = (state_reg == B_IDLE);
    assign load_out    = (state_reg == B_HOLD) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        y100_next  = y100_reg;
        y400_next  = y400_reg;
        month_next = month_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (split_valid)
                begin
                    item_next  = split_data;
                    days_next  = split_data.days;
                    year_next  = EPOCH_YEAR;
                    y100_next  = Y100_START;
                    y400_next  = Y400_START;
                    state_next = B_YEAR;
                end
            end
            B_YEAR:
            begin
                if (days_reg >= DAYS_W'(year_len))
                begin
                    days_next = days_reg - DAYS_W'(year_len);
                    year_next = year_reg + 1'b1;
                    y100_next = (y100_reg == Y100_LAST) ? '0 : y100_reg + 1'b1;
                    y400_next = (y400_reg == Y400_LAST) ? '0 : y400_reg + 1'b1;
                end
                else
                begin
                    month_next = '0;
                    state_next = B_MONTH;
                end
            end
            B_MONTH:
            begin
                if ((month_reg < DECEMBER_IDX) && (days_reg >= DAYS_W'(month_len)))
                begin
                    days_next  = days_reg - DAYS_W'(month_len);
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    state_next = B_HOLD;
                end
            end
            B_HOLD:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        y100_reg  <= y100_next;
        y400_reg  <= y400_next;
        month_reg <= month_next;
        if (load_out)
        begin
            o_sec_reg   <= item_reg.sec;
            o_min_reg   <= item_reg.min;
            o_hour_reg  <= item_reg.hour;
            o_day_reg   <= days_reg[DAY_W-1:0] + 1'b1;
            o_month_reg <= month_reg + 1'b1;
            o_year_reg  <= year_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.second_of_minute = o_sec_reg;
    assign out_ch.minute_of_hour   = o_min_reg;
    assign out_ch.hour_of_day      = o_hour_reg;
    assign out_ch.day_of_month     = o_day_reg;
    assign out_ch.month_of_year    = o_month_reg;
    assign out_ch.full_year        = o_year_reg;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// The time an item spends in the block grows with Y, the whole years past 1970, and with
// M, the month index; it is longest for a date late in December 2105.
// Throughput: one item per back-end walk, set by the year and month stepping loop, while
// the output takes results; the front end's division overlaps with the previous walk.
// Reset (rst_n, asynchronous, active low) empties the queue and the output register; no
// item is in flight afterwards.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    e2c_epoch_if.sink in_ch,
    e2c_cal_if.source out_ch
);

    // The front end splits seconds, minutes and hours off with reciprocal multiplies,
    // one shared multiplier used three times, and hands the remaining day count on.
    logic   front_valid;
    logic   front_ready;
    split_t front_data;

    // The back end walks the calendar one year, then one month, per cycle.
    logic   back_valid;
    logic   back_ready;
    split_t back_data;

    e2c_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .split_valid (front_valid),
        .split_ready (front_ready),
        .split_data  (front_data)
    );

    // The queue lets the front end take and split the next item while the back end
    // is still walking the years of the previous one.
    e2c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_data)
    );

    e2c_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .split_valid (back_valid),
        .split_ready (back_ready),
        .split_data  (back_data),
        .out_ch      (out_ch)
    );

endmodule

// ===== tb/epoch_seconds_to_calendar_tb.sv =====
// Self-checking testbench for the epoch seconds to calendar converter.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;
    import e2c_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 600;
    // The limit covers every item taking as long as the slowest one plus the largest drawn
    // gap on each side, with several times that margin.
    localparam int unsigned CYCLE_LIMIT  = 500000;
    // Cycles allowed after the last expected item, enough for one more full walk.
    localparam int unsigned DRAIN_CYCLES = 400;

    // One calendar item as it leaves the block, at the block's own field widths.
    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   min;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } calendar_t;

    // Holds the calendar dates still owed by the block, oldest first, and checks each
    // item that comes out against the oldest of them.
    class calendar_scoreboard;
        calendar_t   due_dates[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Full Gregorian rule: every fourth year, but not centuries unless divisible by 400.
        static function bit is_leap(int unsigned yr);
            if (yr % 400 == 0)
                return 1'b1;
            if (yr % 100 == 0)
                return 1'b0;
            return (yr % 4 == 0);
        endfunction

        static function int unsigned month_days(int unsigned yr, int unsigned mon);
            case (mon)
                2:          return is_leap(yr) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        // Splits off the time of day, then walks whole years and whole months.
        static function calendar_t calendar_of(logic [EPOCH_W-1:0] secs);
            int unsigned rest;
            int unsigned days;
            int unsigned yr;
            int unsigned mon;
            calendar_t   date;
            date.sec  = SEC_W'(secs % 60);
            rest      = secs / 60;
            date.min  = MIN_W'(rest % 60);
            rest      = rest / 60;
            date.hour = HOUR_W'(rest % 24);
            days      = rest / 24;
            yr = 1970;
            while (days >= (is_leap(yr) ? 366 : 365))
            begin
                days -= is_leap(yr) ? 366 : 365;
                yr++;
            end
            mon = 1;
            while (mon < 12 && days >= month_days(yr, mon))
            begin
                days -= month_days(yr, mon);
                mon++;
            end
            date.day   = DAY_W'(days + 1);
            date.month = MONTH_W'(mon);
            date.year  = YEAR_W'(yr);
            return date;
        endfunction

        function void note_epoch(logic [EPOCH_W-1:0] secs);
            due_dates.push_back(calendar_of(secs));
        endfunction

        function int unsigned pending();
            return due_dates.size();
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(calendar_t got);
            calendar_t want;
            if (due_dates.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                         $time, got.year, got.month, got.day, got.hour, got.min, got.sec);
                errors++;
                return;
            end
            want = due_dates.pop_front();
            check_field("second_of_minute", want.sec, got.sec);
            check_field("minute_of_hour", want.min, got.min);
            check_field("hour_of_day", want.hour, got.hour);
            check_field("day_of_month", want.day, got.day);
            check_field("month_of_year", want.month, got.month);
            check_field("full_year", want.year, got.year);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // When set, neither side idles, so items go through back to back.
    bit steady = 1'b0;

    calendar_scoreboard dates;

    e2c_epoch_if epoch_ch ();
    e2c_cal_if   cal_ch ();

    epoch_seconds_to_calendar u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (epoch_ch),
        .out_ch (cal_ch)
    );

    // 20 ns period: ten nanoseconds low, then ten high.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Wait drawn afresh for every item on either side, unless a steady stretch is on.
    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    // Seconds since the epoch of a given calendar time. The caller keeps the date within
    // the range it wants; the sum is wide enough to show when it passes 32 bits.
    function automatic longint unsigned epoch_of(int unsigned yr, int unsigned mon,
                                                 int unsigned day, int unsigned hh,
                                                 int unsigned mm, int unsigned ss);
        longint unsigned days;
        days = 0;
        for (int unsigned y = 1970; y < yr; y++)
            days += calendar_scoreboard::is_leap(y) ? 366 : 365;
        for (int unsigned m = 1; m < mon; m++)
            days += calendar_scoreboard::month_days(yr, m);
        days += day - 1;
        return days * 86400 + hh * 3600 + mm * 60 + ss;
    endfunction

    // Random epochs: a share spread over the whole 32-bit range, a share placed up to two
    // seconds after the start or before the end of the 1st, the 28th or the last day of a
    // month, and a share in the first few years, which keeps many of the walks short.
    function automatic logic [EPOCH_W-1:0] random_epoch();
        int unsigned     kind;
        int unsigned     yr;
        int unsigned     mon;
        int unsigned     day;
        longint unsigned secs;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom();
        if (kind < 8)
        begin
            yr  = $urandom_range(1970, 2106);
            mon = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0:       day = 1;
                1:       day = 28;
                default: day = calendar_scoreboard::month_days(yr, mon);
            endcase
            secs = epoch_of(yr, mon, day, 0, 0, 0);
            if ($urandom_range(0, 1))
                secs += $urandom_range(0, 2);
            else
                secs += 86399 - $urandom_range(0, 2);
            // Dates past early February 2106 no longer fit in 32 bits.
            if (secs > 64'hFFFF_FFFF)
                return $urandom();
            return EPOCH_W'(secs);
        end
        return $urandom_range(0, 200000000);
    endfunction

    // Offers one epoch item and returns once the block has taken it. Valid is only
    // lowered when a gap is drawn, so back-to-back items keep it high throughout.
    task automatic send_epoch(logic [EPOCH_W-1:0] secs);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            epoch_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        epoch_ch.valid         <= 1'b1;
        epoch_ch.epoch_seconds <= secs;
        do
            @(posedge clk);
        while (epoch_ch.ready !== 1'b1);
        dates.note_epoch(secs);
    endtask

    // Takes calendar items for the rest of the run, stalling before each one by a drawn
    // number of cycles. Every item taken goes to the scoreboard at once.
    task automatic take_calendar_results();
        int unsigned stall;
        calendar_t   got;
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                cal_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cal_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (cal_ch.valid !== 1'b1);
            got.sec   = cal_ch.second_of_minute;
            got.min   = cal_ch.minute_of_hour;
            got.hour  = cal_ch.hour_of_day;
            got.day   = cal_ch.day_of_month;
            got.month = cal_ch.month_of_year;
            got.year  = cal_ch.full_year;
            dates.check_result(got);
        end
    endtask

    // Watchdog: a hung handshake or a lost item ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // The receiving side holds ready low through reset and starts at the clock edge after it.
    initial
    begin
        cal_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        take_calendar_results();
    end

    initial
    begin
        logic [EPOCH_W-1:0] directed[$];
        dates = new();
        epoch_ch.valid         <= 1'b0;
        epoch_ch.epoch_seconds <= '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items. The first few cover the roll-over of each time-of-day field and
        // both ends of the input range; then the first year boundary, a February in a
        // plain leap year, in a year divisible by 400 and in a century that is not a leap
        // year, and finally a few bit patterns, the sign bit alone among them.
        directed.push_back(32'd0);
        directed.push_back(32'd59);
        directed.push_back(32'd60);
        directed.push_back(32'd3599);
        directed.push_back(32'd3600);
        directed.push_back(32'd86399);
        directed.push_back(32'd86400);
        directed.push_back(32'hFFFF_FFFF);
        directed.push_back(32'hFFFF_FFFE);
        directed.push_back(EPOCH_W'(epoch_of(1970, 12, 31, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(1971, 1, 1, 0, 0, 0)));
        directed.push_back(EPOCH_W'(epoch_of(1972, 2, 28, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(1972, 2, 29, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(1972, 3, 1, 0, 0, 0)));
        directed.push_back(EPOCH_W'(epoch_of(1972, 12, 31, 12, 30, 30)));
        directed.push_back(EPOCH_W'(epoch_of(1999, 12, 31, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(2000, 2, 29, 0, 0, 0)));
        directed.push_back(EPOCH_W'(epoch_of(2000, 12, 31, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(2100, 2, 28, 23, 59, 59)));
        directed.push_back(EPOCH_W'(epoch_of(2100, 3, 1, 0, 0, 0)));
        directed.push_back(32'h7FFF_FFFF);
        directed.push_back(32'h8000_0000);
        directed.push_back(32'hAAAA_AAAA);
        directed.push_back(32'h5555_5555);
        foreach (directed[i])
            send_epoch(directed[i]);

        // Random items. Every hundred items the pacing may switch to a steady stretch
        // in which both sides keep their handshake signals high.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_epoch(random_epoch());
        end
        epoch_ch.valid <= 1'b0;

        while (dates.pending() != 0)
            @(posedge clk);
        // Any stray item the block still puts out in this window is flagged by the checker.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (dates.errors == 0 && dates.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
